>>> sv/ale_pkg.sv
// Shared constants, operation and status codes, and controller states for the list engine.
package ale_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;

  typedef enum logic [2:0] {
    FN_INSERT   = 3'd0,
    FN_DELETE   = 3'd1,
    FN_SORT_INS = 3'd2,
    FN_LOCATE   = 3'd3,
    FN_RETRIEVE = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_READ,
    S_FINISH
  } state_t;

endpackage

>>> sv/array_list_engine.sv
// Bounded list of signed words in one RAM: insert, delete, sorted insert, locate, retrieve.
// Rejected requests go straight to the result; retrieve reads the addressed word; insert and
// delete shift the entries behind the position one by one; locate compares entries in order,
// and sorted insert scans for the first entry not less than the word, then shifts as insert.
// One request at a time: s_tready is high only in idle, entered again as the result is registered;
// an output stall holds the engine in finish. Reset empties the list; RAM not cleared.
module array_list_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[7:0], data[39:8]
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // found_index[7:0], value[39:8], entry_count[48:40], zeros
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam logic [ale_pkg::CNT_W-1:0] CAP = ale_pkg::CNT_W'(ale_pkg::CAPACITY);

  ale_pkg::state_t state, state_next;

  logic [ale_pkg::WORD_W-1:0] mem [ale_pkg::CAPACITY];
  logic signed [ale_pkg::WORD_W-1:0] rdata;
  logic [ale_pkg::IDX_W-1:0]  mem_raddr, mem_waddr;
  logic [ale_pkg::WORD_W-1:0] mem_wdata;
  logic                       mem_we;

  logic [2:0]                 op;
  logic [ale_pkg::IDX_W-1:0]  in_pos;
  logic signed [ale_pkg::WORD_W-1:0] in_data;
  logic [2:0]                 in_func;
  logic signed [ale_pkg::WORD_W-1:0] data_r;
  logic [ale_pkg::CNT_W-1:0]  count;
  logic [ale_pkg::CNT_W-1:0]  rd_idx;
  logic                       rd_go;
  logic                       pend;
  logic [ale_pkg::IDX_W-1:0]  pend_addr;
  logic [ale_pkg::IDX_W-1:0]  ins_pos;
  ale_pkg::status_t           res_status;
  logic [ale_pkg::IDX_W-1:0]  res_idx;
  logic [ale_pkg::WORD_W-1:0] res_value;

  logic                       accept;
  logic                       issue;
  logic                       scan_hit;
  logic                       scan_end;
  logic                       shift_done;
  logic                       out_free;
  logic [ale_pkg::CNT_W-1:0]  pos_ext;

  assign in_pos   = s_tdata[7:0];
  assign in_data  = s_tdata[39:8];
  assign in_func  = s_tuser;
  assign pos_ext  = {1'b0, in_pos};
  assign s_tready = (state == ale_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign issue      = (rd_idx < count);
  assign scan_hit   = pend && ((op == ale_pkg::FN_SORT_INS) ? (rdata >= data_r)
                                                           : (rdata == data_r));
  assign scan_end   = !pend && !issue;
  assign shift_done = !rd_go && !pend;
  assign out_free   = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ale_pkg::S_IDLE: begin
        if (s_tvalid) begin
          case (in_func)
            ale_pkg::FN_INSERT:
              state_next = (pos_ext > count || count == CAP) ? ale_pkg::S_FINISH
                                                              : ale_pkg::S_SHIFT_UP;
            ale_pkg::FN_DELETE:
              state_next = (pos_ext >= count) ? ale_pkg::S_FINISH : ale_pkg::S_SHIFT_DN;
            ale_pkg::FN_SORT_INS:
              state_next = (count == CAP) ? ale_pkg::S_FINISH : ale_pkg::S_SCAN;
            ale_pkg::FN_LOCATE:
              state_next = ale_pkg::S_SCAN;
            ale_pkg::FN_RETRIEVE:
              state_next = (pos_ext >= count) ? ale_pkg::S_FINISH : ale_pkg::S_READ;
            default:
              state_next = ale_pkg::S_FINISH;
          endcase
        end
      end
      ale_pkg::S_SCAN: begin
        if (scan_hit || scan_end) begin
          state_next = (op == ale_pkg::FN_SORT_INS) ? ale_pkg::S_SHIFT_UP : ale_pkg::S_FINISH;
        end
      end
      ale_pkg::S_SHIFT_UP, ale_pkg::S_SHIFT_DN: begin
        if (shift_done) begin
          state_next = ale_pkg::S_FINISH;
        end
      end
      ale_pkg::S_READ:   state_next = ale_pkg::S_FINISH;
      ale_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = ale_pkg::S_IDLE;
        end
      end
      default: state_next = ale_pkg::S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_raddr = rd_idx[ale_pkg::IDX_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = rdata;
    unique case (state)
      ale_pkg::S_IDLE: mem_raddr = in_pos;
      ale_pkg::S_SHIFT_UP: begin
        if (pend) begin
          mem_we = 1'b1;
        end else if (!rd_go) begin
          mem_we    = 1'b1;
          mem_waddr = ins_pos;
          mem_wdata = data_r;
        end
      end
      ale_pkg::S_SHIFT_DN: mem_we = pend;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ale_pkg::S_IDLE;
      count    <= '0;
      rd_go    <= 1'b0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ale_pkg::S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ale_pkg::S_IDLE: begin
          pend <= 1'b0;
          if (accept && in_func == ale_pkg::FN_INSERT) begin
            rd_go <= (pos_ext != count);
          end else if (accept && in_func == ale_pkg::FN_DELETE) begin
            rd_go <= ((pos_ext + 1'b1) < count);
          end else begin
            rd_go <= 1'b0;
          end
        end
        ale_pkg::S_SCAN: begin
          if (scan_hit || scan_end) begin
            pend  <= 1'b0;
            rd_go <= scan_hit;
          end else begin
            pend <= issue;
          end
        end
        ale_pkg::S_SHIFT_UP: begin
          pend <= rd_go;
          if (rd_go && rd_idx[ale_pkg::IDX_W-1:0] == ins_pos) begin
            rd_go <= 1'b0;
          end
          if (shift_done) begin
            count <= count + 1'b1;
          end
        end
        ale_pkg::S_SHIFT_DN: begin
          pend <= rd_go;
          if (rd_go && (rd_idx + 1'b1) == count) begin
            rd_go <= 1'b0;
          end
          if (shift_done) begin
            count <= count - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      ale_pkg::S_IDLE: begin
        if (accept) begin
          op        <= in_func;
          data_r    <= in_data;
          ins_pos   <= in_pos;
          res_idx   <= '0;
          res_value <= '0;
          case (in_func)
            ale_pkg::FN_INSERT: begin
              rd_idx <= count - 1'b1;
              if (pos_ext > count) begin
                res_status <= ale_pkg::ST_BADPOS;
              end else if (count == CAP) begin
                res_status <= ale_pkg::ST_FULL;
              end else begin
                res_status <= ale_pkg::ST_OK;
              end
            end
            ale_pkg::FN_DELETE: begin
              rd_idx <= pos_ext + 1'b1;
              if (pos_ext >= count) begin
                res_status <= ale_pkg::ST_BADPOS;
              end else begin
                res_status <= ale_pkg::ST_OK;
              end
            end
            ale_pkg::FN_SORT_INS: begin
              rd_idx <= '0;
              if (count == CAP) begin
                res_status <= ale_pkg::ST_FULL;
              end else begin
                res_status <= ale_pkg::ST_OK;
              end
            end
            ale_pkg::FN_RETRIEVE: begin
              rd_idx <= '0;
              if (pos_ext >= count) begin
                res_status <= ale_pkg::ST_BADPOS;
              end else begin
                res_status <= ale_pkg::ST_OK;
              end
            end
            default: begin
              rd_idx     <= '0;
              res_status <= ale_pkg::ST_OK;
            end
          endcase
        end
      end
      ale_pkg::S_SCAN: begin
        pend_addr <= rd_idx[ale_pkg::IDX_W-1:0];
        if (scan_hit || scan_end) begin
          rd_idx <= count - 1'b1;
          if (op == ale_pkg::FN_SORT_INS) begin
            ins_pos <= scan_hit ? pend_addr : count[ale_pkg::IDX_W-1:0];
            res_idx <= scan_hit ? pend_addr : count[ale_pkg::IDX_W-1:0];
          end else if (scan_hit) begin
            res_idx <= pend_addr;
          end else begin
            res_status <= ale_pkg::ST_NOTFOUND;
          end
        end else if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
      ale_pkg::S_SHIFT_UP: begin
        if (rd_go) begin
          pend_addr <= rd_idx[ale_pkg::IDX_W-1:0] + 1'b1;
          rd_idx    <= rd_idx - 1'b1;
        end
      end
      ale_pkg::S_SHIFT_DN: begin
        if (rd_go) begin
          pend_addr <= rd_idx[ale_pkg::IDX_W-1:0] - 1'b1;
          rd_idx    <= rd_idx + 1'b1;
        end
      end
      ale_pkg::S_READ: res_value <= rdata;
      ale_pkg::S_FINISH: begin
        if (out_free) begin
          m_tuser <= res_status;
          m_tdata <= {7'd0, count, res_value, res_idx};
        end
      end
      default: ;
    endcase
  end

endmodule

>>> tb/tb_array_list_engine.sv
// Testbench for array_list_engine: random and directed list requests checked against a list model.
module tb_array_list_engine;
  import ale_pkg::*;

  localparam logic [2:0] FN_SPARE_LO  = 3'd5;
  localparam logic [2:0] FN_SPARE_HI  = 3'd7;
  localparam int         LONG_HOLD    = 300;
  localparam int         DRAIN_CYCLES = 2 * CAPACITY + 8;

  typedef struct {
    status_t            status;
    logic [7:0]         found_index;
    logic signed [31:0] value;
    logic [8:0]         entry_count;
  } list_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // position[7:0], data[39:8]
  logic [2:0]  s_tuser  = '0;   // func[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;         // found_index[7:0], value[39:8], entry_count[48:40], zeros
  logic [1:0]  m_tuser;         // status[1:0]

  logic signed [31:0] shadow_list [CAPACITY];
  int                 shadow_count = 0;
  list_result_t       expected_results [$];
  int                 mismatch_count = 0;

  bit sender_idles = 1'b1;
  bit sink_idles   = 1'b1;
  bit hold_request = 1'b0;
  int stall_left   = 0;

  array_list_engine DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic void open_slot(input int at, input logic signed [31:0] word);
    for (int i = shadow_count; i > at; i--) shadow_list[i] = shadow_list[i - 1];
    shadow_list[at] = word;
    shadow_count++;
  endfunction

  function automatic void predict_request(input logic [2:0] fn, input logic [7:0] pos,
                                          input logic signed [31:0] word);
    list_result_t r;
    int i;
    r.status      = ST_OK;
    r.found_index = '0;
    r.value       = '0;
    case (fn)
      FN_INSERT: begin
        if (pos > shadow_count) r.status = ST_BADPOS;
        else if (shadow_count >= CAPACITY) r.status = ST_FULL;
        else open_slot(pos, word);
      end
      FN_DELETE: begin
        if (pos >= shadow_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_count--;
        end
      end
      FN_SORT_INS: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          i = 0;
          while (i < shadow_count && shadow_list[i] < word) i++;
          open_slot(i, word);
          r.found_index = i[7:0];
        end
      end
      FN_LOCATE: begin
        i = 0;
        while (i < shadow_count && shadow_list[i] != word) i++;
        if (i == shadow_count) r.status = ST_NOTFOUND;
        else r.found_index = i[7:0];
      end
      FN_RETRIEVE: begin
        if (pos >= shadow_count) r.status = ST_BADPOS;
        else r.value = shadow_list[pos];
      end
      default: ;
    endcase
    r.entry_count = shadow_count[8:0];
    expected_results.push_back(r);
  endfunction

  function automatic logic signed [31:0] pick_word();
    int r;
    r = $urandom_range(0, 11);
    if (r < 3 && shadow_count > 0) return shadow_list[$urandom_range(0, shadow_count - 1)];
    if (r < 6) return $urandom_range(0, 16) - 8;
    if (r == 6) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_position();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(0, (shadow_count < 255) ? shadow_count : 255));
  endfunction

  task automatic send_request(input logic [2:0] fn, input logic [7:0] pos,
                              input logic signed [31:0] word);
    int gap;
    @(negedge clk);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {word, pos};
    do @(posedge clk); while (!s_tready);
    predict_request(fn, pos, word);
  endtask

  task automatic release_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic send_random_request();
    int r;
    logic [2:0] fn;
    r = $urandom_range(0, 99);
    if (r < 22) fn = (shadow_count > 60) ? FN_DELETE : FN_INSERT;
    else if (r < 42) fn = FN_DELETE;
    else if (r < 62) fn = FN_SORT_INS;
    else if (r < 77) fn = FN_LOCATE;
    else if (r < 95) fn = FN_RETRIEVE;
    else fn = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
    send_request(fn, pick_position(), pick_word());
  endtask

  task automatic test_edge_requests();
    send_request(FN_RETRIEVE, 8'd0, 32'sd0);
    send_request(FN_DELETE, 8'd0, 32'sd0);
    send_request(FN_LOCATE, 8'd0, 32'sd0);
    send_request(FN_INSERT, 8'd1, 32'sd7);
    send_request(FN_INSERT, 8'hFF, 32'sd7);
    send_request(FN_INSERT, 8'd0, 32'sh7FFF_FFFF);
    send_request(FN_INSERT, 8'd0, 32'sh8000_0000);
    send_request(FN_INSERT, 8'd2, 32'sd0);
    send_request(FN_SORT_INS, 8'hFF, 32'sd0);
    send_request(FN_SORT_INS, 8'd0, -32'sd1);
    send_request(FN_SORT_INS, 8'd0, 32'sh8000_0000);
    send_request(FN_SORT_INS, 8'd0, 32'sh7FFF_FFFF);
    send_request(FN_LOCATE, 8'd0, 32'sd0);
    send_request(FN_LOCATE, 8'd0, 32'sd5);
    send_request(FN_LOCATE, 8'hFF, 32'sh8000_0000);
    send_request(FN_RETRIEVE, 8'd0, 32'sd0);
    send_request(FN_RETRIEVE, 8'(shadow_count - 1), 32'sd0);
    send_request(FN_RETRIEVE, 8'(shadow_count), 32'sd0);
    send_request(FN_DELETE, 8'(shadow_count), 32'sd0);
    send_request(FN_DELETE, 8'(shadow_count - 1), 32'sd0);
    send_request(FN_DELETE, 8'd0, 32'sd0);
    send_request(FN_DELETE, 8'd1, 32'sd0);
    for (int f = FN_SPARE_LO; f <= FN_SPARE_HI; f++) send_request(3'(f), 8'hFF, $urandom);
    release_input();
  endtask

  task automatic test_fill_to_capacity();
    int r;
    while (shadow_count < CAPACITY) begin
      if ($urandom_range(0, 1) == 0) send_request(FN_SORT_INS, 8'($urandom), pick_word());
      else send_request(FN_INSERT, pick_position(), pick_word());
    end
    send_request(FN_INSERT, 8'd0, pick_word());
    send_request(FN_INSERT, 8'hFF, pick_word());
    send_request(FN_SORT_INS, 8'd0, pick_word());
    send_request(FN_RETRIEVE, 8'hFF, 32'sd0);
    send_request(FN_LOCATE, 8'd0, shadow_list[CAPACITY - 1]);
    send_request(FN_DELETE, 8'hFF, 32'sd0);
    send_request(FN_INSERT, 8'hFF, $urandom);
    send_request(FN_SORT_INS, 8'd0, 32'sh7FFF_FFFF);
    while (shadow_count > 0) begin
      r = $urandom_range(0, 7);
      if (r == 0) send_request(FN_RETRIEVE, pick_position(), 32'sd0);
      else if (r == 1) send_request(FN_LOCATE, 8'($urandom), pick_word());
      else send_request(FN_DELETE, 8'($urandom_range(0, shadow_count - 1)), $urandom);
    end
    release_input();
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_random_request();
    release_input();
  endtask

  task automatic test_output_stall();
    sender_idles = 1'b0;
    hold_request = 1'b1;
    repeat (12) send_random_request();
    release_input();
    sender_idles = 1'b1;
  endtask

  task automatic test_streaming(input int count);
    sender_idles = 1'b0;
    sink_idles   = 1'b0;
    repeat (count) send_random_request();
    release_input();
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_request) begin
      hold_request <= 1'b0;
      m_tready     <= 1'b0;
      stall_left   <= LONG_HOLD - 1;
    end else if (sink_idles && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.status) begin
          $error("status field: expected %0d, got %0d", want.status, m_tuser);
          mismatch_count++;
        end
        if (m_tdata[7:0] !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index, m_tdata[7:0]);
          mismatch_count++;
        end
        if (m_tdata[39:8] !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, $signed(m_tdata[39:8]));
          mismatch_count++;
        end
        if (m_tdata[48:40] !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, m_tdata[48:40]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_edge_requests();
    test_fill_to_capacity();
    test_random_mix(1050);
    test_output_stall();
    test_streaming(250);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
sv/ale_pkg.sv
sv/array_list_engine.sv
tb/tb_array_list_engine.sv
